>>> sv/sts_pkg.sv
// Shared types and constants for the sorted key table.
package sts_pkg;

  // Capacity default and the widest address the capacity range needs
  localparam int unsigned DefCapacity = 32;
  localparam int unsigned MaxAw       = 12;

  // Width of one field of the payload ports
  localparam int unsigned OpW    = 2;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned EcntW  = 6;

  typedef enum logic [OpW-1:0] {
    OpSearch = 2'd0,
    OpInsert = 2'd1,
    OpDelete = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    StOk     = 2'd0,
    StAbsent = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SSrch,
    SCmp,
    SHit,
    SUp,
    SIns,
    SDn
  } state_e;

  // One table entry
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [ValW-1:0]        val;
  } sts_entry_t;

  // Access request from the sequencer to the table memory
  typedef struct packed {
    logic             re;
    logic [MaxAw-1:0] raddr;
    logic             we;
    logic [MaxAw-1:0] waddr;
    sts_entry_t       wdata;
  } sts_mem_req_t;

endpackage

>>> sv/sts_mem.sv
// Table memory: one write and one registered read port.
module sts_mem #(
  parameter int unsigned Depth = 32
) (
  input  logic                  clk_i,
  input  sts_pkg::sts_mem_req_t req_i,
  output sts_pkg::sts_entry_t   rdata_o
);
  import sts_pkg::*;

  localparam int unsigned Aw = $clog2(Depth);

  sts_entry_t mem_q [Depth];
  sts_entry_t rdata_q;

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[Aw-1:0]] <= req_i.wdata;
    end
  end

  // Registered read: the entry shows on rdata_o in the cycle after the request
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[Aw-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sts_ctrl.sv
// Sequencer: binary search, then shift entries up or down through the memory.
module sts_ctrl #(
  parameter int unsigned Capacity = sts_pkg::DefCapacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sts_pkg::OpW-1:0]     op_i,
  input  logic signed [sts_pkg::KeyW-1:0] key_i,
  input  logic [sts_pkg::ValW-1:0]    value_i,
  output logic                        busy_o,
  output sts_pkg::sts_mem_req_t       mem_req_o,
  input  sts_pkg::sts_entry_t         mem_rdata_i,
  output logic                        done_o,
  output logic [sts_pkg::StatW-1:0]   status_o,
  output logic [sts_pkg::ValW-1:0]    found_value_o,
  output logic [sts_pkg::EcntW-1:0]   entry_count_o
);
  import sts_pkg::*;

  localparam int unsigned Cw = $clog2(Capacity + 1);

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0]      val_q, val_d;
  logic [Cw-1:0]        lo_q, lo_d;
  logic [Cw-1:0]        hi_q, hi_d;
  logic [Cw-1:0]        mid_q, mid_d;
  logic [Cw-1:0]        w_q, w_d;
  logic [Cw-1:0]        count_q, count_d;
  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [ValW-1:0]      fv_q, fv_d;

  logic [Cw-1:0]        mid;
  logic [Cw:0]          w_plus2;
  logic                 hit;
  sts_mem_req_t         req;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign w_plus2 = {1'b0, w_q} + (Cw+1)'(2);
  assign hit     = (lo_q < count_q) && (mem_rdata_i.key == key_q);

  // Next state, memory requests and result
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    w_d      = w_q;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = status_q;
    fv_d     = fv_q;
    req      = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          op_d    = op_e'(op_i);
          key_d   = key_i;
          val_d   = value_i;
          lo_d    = '0;
          hi_d    = count_q;
          state_d = SSrch;
        end
      end
      SSrch: begin
        if (lo_q < hi_q) begin
          req.re    = 1'b1;
          req.raddr = MaxAw'(mid);
          mid_d     = mid;
          state_d   = SCmp;
        end else begin
          // fetch the lower bound for the hit check
          req.re    = 1'b1;
          req.raddr = MaxAw'(lo_q);
          state_d   = SHit;
        end
      end
      SCmp: begin
        if (mem_rdata_i.key < key_q) begin
          lo_d = mid_q + Cw'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = SSrch;
      end
      SHit: begin
        fv_d     = '0;
        status_d = StAbsent;
        state_d  = SIdle;
        done_d   = 1'b1;
        case (op_q)
          OpSearch: begin
            if (hit) begin
              status_d = StOk;
              fv_d     = mem_rdata_i.val;
            end
          end
          OpInsert: begin
            if (!hit && count_q == Cw'(Capacity)) begin
              status_d = StFull;
            end else if (!hit) begin
              done_d = 1'b0;
              if (count_q > lo_q) begin
                req.re    = 1'b1;
                req.raddr = MaxAw'(count_q - Cw'(1));
                w_d       = count_q;
                state_d   = SUp;
              end else begin
                state_d = SIns;
              end
            end
          end
          OpDelete: begin
            if (hit) begin
              if ((lo_q + Cw'(1)) < count_q) begin
                done_d    = 1'b0;
                req.re    = 1'b1;
                req.raddr = MaxAw'(lo_q + Cw'(1));
                w_d       = lo_q;
                state_d   = SDn;
              end else begin
                status_d = StOk;
                count_d  = count_q - Cw'(1);
              end
            end
          end
          default: begin
            status_d = StAbsent;
          end
        endcase
      end
      SUp: begin
        // move entry w-1 up to w, prefetch w-2
        req.we    = 1'b1;
        req.waddr = MaxAw'(w_q);
        req.wdata = mem_rdata_i;
        if ((w_q - Cw'(1)) > lo_q) begin
          req.re    = 1'b1;
          req.raddr = MaxAw'(w_q - Cw'(2));
          w_d       = w_q - Cw'(1);
        end else begin
          state_d = SIns;
        end
      end
      SIns: begin
        req.we        = 1'b1;
        req.waddr     = MaxAw'(lo_q);
        req.wdata.key = key_q;
        req.wdata.val = val_q;
        count_d       = count_q + Cw'(1);
        status_d      = StOk;
        fv_d          = '0;
        done_d        = 1'b1;
        state_d       = SIdle;
      end
      SDn: begin
        // move entry w+1 down to w, prefetch w+2
        req.we    = 1'b1;
        req.waddr = MaxAw'(w_q);
        req.wdata = mem_rdata_i;
        if (w_plus2 < {1'b0, count_q}) begin
          req.re    = 1'b1;
          req.raddr = MaxAw'(w_plus2);
          w_d       = w_q + Cw'(1);
        end else begin
          count_d  = count_q - Cw'(1);
          status_d = StOk;
          fv_d     = '0;
          done_d   = 1'b1;
          state_d  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Item and search registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    w_q      <= w_d;
    status_q <= status_d;
    fv_q     <= fv_d;
  end

  assign busy_o        = (state_q != SIdle);
  assign mem_req_o     = req;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = fv_q;
  assign entry_count_o = EcntW'(count_q);

endmodule

>>> sv/sorted_table_binary_search.sv
// Sorted key table with binary search, insert and delete.
//
// Usage:
//   Drive op_i, key_i and value_i and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy stays high while
//   the item is worked on. One result per item appears on status_o,
//   found_value_o and entry_count_o for exactly one cycle, marked by done_o;
//   the receiver cannot stall it, and busy is already low in that cycle so
//   the next item may be started alongside the result.
//   Each binary search step is a memory read, then a compare; a search
//   ends with a read of the lower bound and the hit check. An insert then
//   moves each entry above the slot up one place and writes the new entry,
//   a delete moves each entry above the hit down one place. The
//   single-read, single-write table memory sets the shift rate. With 32
//   entries the worst case is a delete of the lowest key from a full table.
//   Reset clears the entry count and the sequencer; table contents are not
//   cleared, and an entry read beyond the entry count never counts as a hit.
module sorted_table_binary_search #(
  parameter int unsigned CAPACITY = sts_pkg::DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sts_pkg::OpW-1:0]       op_i,
  input  logic signed [sts_pkg::KeyW-1:0] key_i,
  input  logic [sts_pkg::ValW-1:0]      value_i,
  output logic                          done_o,
  output logic [sts_pkg::StatW-1:0]     status_o,
  output logic [sts_pkg::ValW-1:0]      found_value_o,
  output logic [sts_pkg::EcntW-1:0]     entry_count_o
);
  import sts_pkg::*;

  sts_mem_req_t mem_req;
  sts_entry_t   mem_rdata;

  sts_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .op_i          (op_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .busy_o        (busy),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .entry_count_o (entry_count_o)
  );

  sts_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

>>> sv/sts_checker.sv
// Port checker for the sorted key table, bound to the top level.
module sts_checker #(
  parameter int unsigned Capacity = sts_pkg::DefCapacity
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [sts_pkg::StatW-1:0]   status_o,
  input logic [sts_pkg::ValW-1:0]    found_value_o,
  input logic [sts_pkg::EcntW-1:0]   entry_count_o
);
  import sts_pkg::*;

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // A result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result only shows while the block is ready again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Only a successful search carries a value
  a_fv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != StOk) |-> (found_value_o == '0))
    else $error("found value not zero on a failed request");

  // A full refusal reports a full table
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == StFull) |-> (entry_count_o == EcntW'(Capacity)))
    else $error("full status with table not full");

endmodule

bind sorted_table_binary_search sts_checker #(
  .Capacity (CAPACITY)
) u_sts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .found_value_o (found_value_o),
  .entry_count_o (entry_count_o)
);
